### hw/rtl/vqs_pkg.sv
package vqs_pkg;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [2:0] REG_ASSESS_UPPER  = 3'd0;
  localparam logic [2:0] REG_ASSESS_LOWER  = 3'd1;
  localparam logic [2:0] REG_QUALIFY_UPPER = 3'd2;
  localparam logic [2:0] REG_QUALIFY_LOWER = 3'd3;
  localparam logic [2:0] REG_THREE_WIRE    = 3'd4;

  localparam logic [13:0] RATE_FULL = 14'd10000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] volt_a;
    logic [15:0] volt_b;
    logic [15:0] volt_c;
    logic [1:0]  clear_select;
    logic        read_period;
    logic [1:0]  read_phase;
  } item_t;

  typedef struct packed {
    logic [10:0] phase_status;
    logic [31:0] monitor_minutes;
    logic [31:0] below_minutes;
    logic [31:0] over_minutes;
    logic [13:0] pass_rate;
    logic [13:0] exceed_rate;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture item
    logic tick_rec;   // update record rec_idx of both sets
    logic clear;      // apply clear select
    logic read_sel;   // latch the record being read, prime divider
    logic div_step;   // one quotient bit
    logic finish;     // form the result
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       div_zero;
  } stat_t;

endpackage

### hw/rtl/vqs_ctrl.sv
module vqs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  vqs_pkg::stat_t stat,
  output vqs_pkg::cmd_t cmd,
  output logic [1:0]    rec_idx
);
  import vqs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_TICK = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign rec_idx    = cnt_r[1:0];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
          cnt_nxt   = '0;
        end
      end
      S_DEC: begin
        unique case (stat.kind)
          KIND_TICK: state_nxt = S_TICK;
          KIND_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = S_FIN;
          end
          KIND_READ: begin
            cmd.read_sel = 1'b1;
            state_nxt    = S_DIV;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_TICK: begin
        cmd.tick_rec = 1'b1;
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r == 6'd3) state_nxt = S_FIN;
      end
      S_DIV: begin
        // 47-bit dividend, one bit a cycle
        if (stat.div_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.div_step = 1'b1;
          cnt_nxt      = cnt_r + 6'd1;
          if (cnt_r == 6'd46) state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### hw/rtl/vqs_dp.sv
module vqs_dp #(
  parameter int PHASE_COUNT         = 3,
  parameter int DAY_CAP             = 1440,
  parameter int MONTH_CAP           = 44640,
  parameter int DAY_CORRUPT_LIMIT   = 2880,
  parameter int MONTH_CORRUPT_LIMIT = 89280
) (
  input  logic             clk,
  input  logic             rst_n,
  input  vqs_pkg::item_t   item,
  input  logic [15:0]      assess_upper,
  input  logic [15:0]      assess_lower,
  input  logic [15:0]      qualify_upper,
  input  logic [15:0]      qualify_lower,
  input  logic             three_wire,
  input  vqs_pkg::cmd_t    cmd,
  input  logic [1:0]       rec_idx,
  output vqs_pkg::stat_t   stat,
  output vqs_pkg::result_t result
);
  import vqs_pkg::*;

  item_t       item_r;
  logic [31:0] day_r   [12];
  logic [31:0] month_r [12];
  logic [10:0] status;
  logic [10:0] status_r;

  // divider
  logic [46:0] dvd_r, dvd_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dvs_r;
  logic [31:0] mon_r, bel_r, ovr_r;
  logic [33:0] rem_sh;
  result_t     res_r, res_nxt;

  assign stat.kind     = item_r.kind;
  assign stat.div_zero = (dvs_r == 32'd0);
  assign result        = res_r;

  // classification, combinational on the held item
  always_comb begin
    logic [15:0] v;
    status = '0;
    for (int i = 0; i < 3; i++) begin
      v = (i == 0) ? item_r.volt_a : (i == 1) ? item_r.volt_b : item_r.volt_c;
      if (!(three_wire && i == 1) && v < assess_upper && v > assess_lower) begin
        status[8+i] = 1'b1;
        if (v > qualify_upper) status[4+i] = 1'b1;
        if (v < qualify_lower) status[i]   = 1'b1;
      end
    end
  end

  function automatic logic [95:0] upd_phase(input logic [95:0] rec, input logic [2:0] f,
                                            input logic [31:0] cap, input logic [31:0] bad);
    logic [31:0] m, b, o;
    m = rec[31:0]; b = rec[63:32]; o = rec[95:64];
    if (m > bad || b > bad || o > bad) begin
      m = '0; b = '0; o = '0;
    end else if (m >= cap || b >= cap || o >= cap) begin
      return rec;
    end
    if (f[0]) m = m + 32'd1;
    if (f[1]) b = b + 32'd1;
    if (f[2]) o = o + 32'd1;
    return {o, b, m};
  endfunction

  logic        tot_ok;
  logic [2:0]  pflags;
  logic        p_en;
  logic [3:0]  base;
  logic [1:0]  pidx;
  logic [95:0] d_new, m_new;

  always_comb begin
    tot_ok = three_wire ? (status[8] && status[10]) : (status[10:8] == 3'b111);
    base   = 4'd3 * {2'b00, rec_idx};
    pidx   = rec_idx - 2'd1;
    pflags = '0;
    p_en   = 1'b0;
    if (rec_idx == 2'd0) begin
      pflags = {|status[6:4], |status[2:0], tot_ok};
    end else begin
      pflags = {status[{2'b01, pidx}], status[{2'b00, pidx}], status[{2'b10, pidx}]};
      p_en   = (32'(rec_idx) <= 32'(PHASE_COUNT)) && !(three_wire && rec_idx == 2'd2);
    end
    d_new = upd_phase({day_r[base + 4'd2], day_r[base + 4'd1], day_r[base]}, pflags,
                      32'(DAY_CAP), 32'(DAY_CORRUPT_LIMIT));
    m_new = upd_phase({month_r[base + 4'd2], month_r[base + 4'd1], month_r[base]}, pflags,
                      32'(MONTH_CAP), 32'(MONTH_CORRUPT_LIMIT));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 12; i++) begin
        day_r[i]   <= '0;
        month_r[i] <= '0;
      end
    end else if (cmd.tick_rec) begin
      if (rec_idx == 2'd0) begin
        if (tot_ok) begin
          day_r[0]   <= day_r[0] + 32'd1;
          month_r[0] <= month_r[0] + 32'd1;
          if (pflags[1]) begin
            day_r[1]   <= day_r[1] + 32'd1;
            month_r[1] <= month_r[1] + 32'd1;
          end
          if (pflags[2]) begin
            day_r[2]   <= day_r[2] + 32'd1;
            month_r[2] <= month_r[2] + 32'd1;
          end
        end
      end else if (p_en) begin
        {day_r[base + 4'd2], day_r[base + 4'd1], day_r[base]}       <= d_new;
        {month_r[base + 4'd2], month_r[base + 4'd1], month_r[base]} <= m_new;
      end
    end else if (cmd.clear) begin
      for (int i = 0; i < 12; i++) begin
        if (item_r.clear_select[0]) day_r[i]   <= '0;
        if (item_r.clear_select[1]) month_r[i] <= '0;
      end
    end
  end

  // restoring division of (below+over)*10000 by monitor
  always_comb begin
    rem_sh  = {rem_r, dvd_r[46]};
    dvd_nxt = {dvd_r[45:0], 1'b0};
    rem_nxt = rem_sh[32:0];
    if (rem_sh >= {2'b00, dvs_r}) begin
      rem_nxt    = 33'(rem_sh - {2'b00, dvs_r});
      dvd_nxt[0] = 1'b1;
    end
  end

  always_comb begin
    res_nxt = '0;
    if (item_r.kind == KIND_TICK) begin
      res_nxt.phase_status = status_r;
    end else if (item_r.kind == KIND_READ) begin
      res_nxt.monitor_minutes = mon_r;
      res_nxt.below_minutes   = bel_r;
      res_nxt.over_minutes    = ovr_r;
      if (dvs_r == 32'd0) begin
        res_nxt.pass_rate = RATE_FULL;
      end else if (dvd_r > 47'(RATE_FULL)) begin
        res_nxt.exceed_rate = RATE_FULL;
      end else begin
        res_nxt.exceed_rate = dvd_r[13:0];
        res_nxt.pass_rate   = RATE_FULL - dvd_r[13:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= item;
    if (cmd.tick_rec && rec_idx == 2'd0) status_r <= status;
    if (cmd.read_sel) begin
      logic [3:0] rb;
      rb = 4'd3 * {2'b00, item_r.read_phase};
      mon_r <= item_r.read_period ? month_r[rb]         : day_r[rb];
      bel_r <= item_r.read_period ? month_r[rb + 4'd1] : day_r[rb + 4'd1];
      ovr_r <= item_r.read_period ? month_r[rb + 4'd2] : day_r[rb + 4'd2];
      dvs_r <= item_r.read_period ? month_r[rb]         : day_r[rb];
      dvd_r <= ({14'd0, 33'(item_r.read_period ? month_r[rb + 4'd1] : day_r[rb + 4'd1])}
              + {14'd0, 33'(item_r.read_period ? month_r[rb + 4'd2] : day_r[rb + 4'd2])})
              * 47'd10000;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.finish) res_r <= res_nxt;
  end

endmodule

### hw/rtl/voltage_qualification_stats.sv
// Voltage qualification statistics.
// in_*: one item per transfer; tuser = kind, tdata (low bit first) =
// volt_a, volt_b, volt_c, clear_select, read_period, read_phase, zero pad.
// out_*: exactly one result per item; tdata (low bit first) = phase_status,
// monitor_minutes, below_minutes, over_minutes, pass_rate, exceed_rate.
// cfg_*: register writes (index 0..4), accepted in any cycle; write only
// while idle.
// One item at a time: a tick updates the total record and then each phase
// record, one record per cycle; a clear or an unused kind goes straight to the
// result; a read runs the bit-serial rate divider for 47 steps unless the
// record is empty. in_tready rises again in the cycle after the result transfer.
// Results hold on out_tdata while out_tready is low; no new item is taken.
// Reset zeroes all day and month records and the configuration registers.
module voltage_qualification_stats #(
  parameter int PHASE_COUNT         = 3,
  parameter int DAY_CAP             = 1440,
  parameter int MONTH_CAP           = 44640,
  parameter int DAY_CORRUPT_LIMIT   = 2880,
  parameter int MONTH_CORRUPT_LIMIT = 89280
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [55:0]  in_tdata,   // volt_a, volt_b, volt_c, clear_select, read_period, read_phase
  input  logic [1:0]   in_tuser,   // kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // phase_status, monitor, below, over, pass, exceed
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import vqs_pkg::*;

  logic [15:0] au_r, al_r, qu_r, ql_r;
  logic        tw_r;
  item_t       item;
  result_t     result;
  cmd_t        cmd;
  stat_t       stat;
  logic [1:0]  rec_idx;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      au_r <= '0; al_r <= '0; qu_r <= '0; ql_r <= '0; tw_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ASSESS_UPPER:  au_r <= cfg_data;
        REG_ASSESS_LOWER:  al_r <= cfg_data;
        REG_QUALIFY_UPPER: qu_r <= cfg_data;
        REG_QUALIFY_LOWER: ql_r <= cfg_data;
        REG_THREE_WIRE:    tw_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    item.kind         = in_tuser;
    item.volt_a       = in_tdata[15:0];
    item.volt_b       = in_tdata[31:16];
    item.volt_c       = in_tdata[47:32];
    item.clear_select = in_tdata[49:48];
    item.read_period  = in_tdata[50];
    item.read_phase   = in_tdata[52:51];
  end

  assign out_tdata = {1'b0, result.exceed_rate, result.pass_rate, result.over_minutes,
                      result.below_minutes, result.monitor_minutes, result.phase_status};

  vqs_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .stat, .cmd, .rec_idx
  );

  vqs_dp #(
    .PHASE_COUNT(PHASE_COUNT), .DAY_CAP(DAY_CAP), .MONTH_CAP(MONTH_CAP),
    .DAY_CORRUPT_LIMIT(DAY_CORRUPT_LIMIT), .MONTH_CORRUPT_LIMIT(MONTH_CORRUPT_LIMIT)
  ) u_dp (
    .clk, .rst_n, .item,
    .assess_upper(au_r), .assess_lower(al_r), .qualify_upper(qu_r),
    .qualify_lower(ql_r), .three_wire(tw_r),
    .cmd, .rec_idx, .stat, .result
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");
  a_rate_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(result.pass_rate) + 32'(result.exceed_rate) == 32'd10000
                    || (result.pass_rate == 14'd0 && result.exceed_rate == 14'd0)))
    else $error("rates do not sum to full scale");
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd)) else $error("conflicting datapath commands");

endmodule
